[hw/rtl/stbm_pkg.sv]
// Package: types, sizes and control codes of the suffix trie best-match block
package stbm_pkg;

    localparam int NODE_COUNT  = 4096;
    localparam int ALPHABET    = 26;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
    localparam int SYM_W       = 5;
    localparam int LEN_W       = 12;
    localparam int IDX_W       = 16;
    localparam int ROOT_LEN_W  = LEN_W + 1;

    localparam logic [ROOT_LEN_W-1:0] ROOT_EMPTY_LEN = '1;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [SYM_W-1:0] letter;
        logic             last;
        logic [LEN_W-1:0] word_length;
        logic [IDX_W-1:0] word_index;
    } stbm_in_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
        logic             status;
    } stbm_out_t;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  best_len;
        logic [IDX_W-1:0]  best_idx;
    } stbm_node_rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHILD,
        ST_NODE
    } stbm_state_t;

    typedef struct packed {
        logic accept;
        logic node_rd;
        logic commit;
    } stbm_cmd_t;

    typedef struct packed {
        logic item_last;
        logic out_blocked;
    } stbm_stat_t;

endpackage

[hw/rtl/stbm_ctrl.sv]
// Controller: sequences child lookup, node record read and commit of one transaction
module stbm_ctrl
    import stbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  stbm_stat_t stat,
    output stbm_cmd_t  cmd
);

    stbm_state_t state_reg;
    stbm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHILD;
                end
            end
            ST_CHILD: begin
                state_next = ST_NODE;
            end
            ST_NODE: begin
                if (!(stat.item_last && stat.out_blocked)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.accept  = 1'b0;
        cmd.node_rd = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = aresetn;
                cmd.accept = s_valid && aresetn;
            end
            ST_CHILD: begin
                cmd.node_rd = 1'b1;
            end
            ST_NODE: begin
                cmd.commit = !(stat.item_last && stat.out_blocked);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_to_child: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == ST_CHILD)
        else $error("accepted transaction did not start child lookup");
    a_child_to_node: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHILD |=> state_reg == ST_NODE && !cmd.accept)
        else $error("child lookup not followed by node step");
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(stat.item_last && stat.out_blocked))
        else $error("commit while result register blocked");
`endif

endmodule

[hw/rtl/stbm_datapath.sv]
// Datapath: child table, node records, walk cursor, root record and result register
module stbm_datapath
    import stbm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  stbm_in_t   s_data,
    input  stbm_cmd_t  cmd,
    output stbm_stat_t stat,
    output logic       m_valid,
    input  logic       m_ready,
    output stbm_out_t  m_data
);

    logic [NODE_W-1:0]   child_mem [CHILD_DEPTH];
    stbm_node_rec_t      node_mem  [NODE_COUNT];

    logic [NODE_W-1:0]   child_q;
    stbm_node_rec_t      node_q;

    stbm_in_t            item_reg;
    logic [CHILD_AW-1:0] child_addr_reg;
    logic [CHILD_AW-1:0] child_addr_in;
    logic [NODE_W-1:0]   cursor_reg;
    logic [NODE_W-1:0]   cursor_next;
    logic [IDX_W-1:0]    cursor_idx_reg;
    logic [IDX_W-1:0]    cursor_idx_next;
    logic                walk_stopped_reg;
    logic                walk_stopped_next;
    logic                overflow_reg;
    logic                overflow_next;
    logic [NODE_W:0]     next_free_reg;
    logic [ROOT_LEN_W-1:0] root_len_reg;
    logic [IDX_W-1:0]    root_idx_reg;
    logic                root_has_reg;
    logic                m_valid_reg;
    stbm_out_t           m_data_reg;
    stbm_out_t           m_data_next;

    logic                is_ins;
    logic                sym_ok;
    logic                hit;
    logic                full;
    logic                better;
    logic                root_better;
    logic                alloc;
    logic                upd;
    logic                child_we;
    logic                node_we;
    logic [NODE_W-1:0]   node_waddr;
    stbm_node_rec_t      node_wdata;

    assign child_addr_in = CHILD_AW'(cursor_reg) * CHILD_AW'(ALPHABET)
                         + CHILD_AW'(s_data.letter);

    always_ff @(posedge aclk) begin
        if (child_we) begin
            child_mem[child_addr_reg] <= next_free_reg[NODE_W-1:0];
        end
        if (cmd.accept) begin
            child_q <= child_mem[child_addr_in];
        end
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (cmd.node_rd) begin
            node_q <= node_mem[child_q];
        end
    end

    assign is_ins = (item_reg.mode == MODE_INSERT);
    assign sym_ok = int'(item_reg.letter) < ALPHABET;
    assign hit    = sym_ok && (child_q != '0)
                 && ({1'b0, child_q} < next_free_reg)
                 && (node_q.parent == cursor_reg)
                 && (node_q.sym == item_reg.letter);
    assign full   = (next_free_reg == (NODE_W + 1)'(NODE_COUNT));
    assign better = item_reg.word_length < node_q.best_len;
    assign root_better = is_ins && ({1'b0, item_reg.word_length} < root_len_reg);

    always_comb begin
        cursor_next       = cursor_reg;
        cursor_idx_next   = cursor_idx_reg;
        walk_stopped_next = walk_stopped_reg;
        overflow_next     = overflow_reg;
        alloc             = 1'b0;
        upd               = 1'b0;
        if (!walk_stopped_reg) begin
            if (!sym_ok) begin
                walk_stopped_next = 1'b1;
            end else if (hit) begin
                cursor_next = child_q;
                if (is_ins && better) begin
                    upd             = 1'b1;
                    cursor_idx_next = item_reg.word_index;
                end else begin
                    cursor_idx_next = node_q.best_idx;
                end
            end else if (!is_ins) begin
                walk_stopped_next = 1'b1;
            end else if (full) begin
                walk_stopped_next = 1'b1;
                overflow_next     = 1'b1;
            end else begin
                alloc           = 1'b1;
                cursor_next     = next_free_reg[NODE_W-1:0];
                cursor_idx_next = item_reg.word_index;
            end
        end
    end

    always_comb begin
        if (is_ins) begin
            m_data_next.found       = 1'b1;
            m_data_next.match_index = '0;
            m_data_next.status      = overflow_next;
        end else begin
            m_data_next.found       = root_has_reg;
            m_data_next.match_index = (cursor_next == '0) ? root_idx_reg : cursor_idx_next;
            m_data_next.status      = 1'b0;
        end
    end

    assign child_we   = cmd.commit && alloc;
    assign node_we    = cmd.commit && (alloc || upd);
    assign node_waddr = alloc ? next_free_reg[NODE_W-1:0] : child_q;

    always_comb begin
        node_wdata.parent   = alloc ? cursor_reg : node_q.parent;
        node_wdata.sym      = alloc ? item_reg.letter : node_q.sym;
        node_wdata.best_len = item_reg.word_length;
        node_wdata.best_idx = item_reg.word_index;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg       <= s_data;
            child_addr_reg <= child_addr_in;
        end
        if (cmd.commit) begin
            cursor_idx_reg <= cursor_idx_next;
        end
        if (cmd.commit && item_reg.last) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg       <= '0;
            walk_stopped_reg <= 1'b0;
            overflow_reg     <= 1'b0;
            next_free_reg    <= (NODE_W + 1)'(1);
            root_len_reg     <= ROOT_EMPTY_LEN;
            root_idx_reg     <= '0;
            root_has_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.commit) begin
                if (item_reg.last) begin
                    cursor_reg       <= '0;
                    walk_stopped_reg <= 1'b0;
                    overflow_reg     <= 1'b0;
                end else begin
                    cursor_reg       <= cursor_next;
                    walk_stopped_reg <= walk_stopped_next;
                    overflow_reg     <= overflow_next;
                end
                if (alloc) begin
                    next_free_reg <= next_free_reg + (NODE_W + 1)'(1);
                end
                if (root_better) begin
                    root_len_reg <= {1'b0, item_reg.word_length};
                    root_idx_reg <= item_reg.word_index;
                end
                if (is_ins) begin
                    root_has_reg <= 1'b1;
                end
            end
            if (cmd.commit && item_reg.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.item_last   = item_reg.last;
    assign stat.out_blocked = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;

`ifndef SYNTH
    a_free_range: assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg != '0 && next_free_reg <= (NODE_W + 1)'(NODE_COUNT))
        else $error("free node pointer out of range");
    a_alloc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        child_we |=> next_free_reg == $past(next_free_reg) + (NODE_W + 1)'(1))
        else $error("node allocation did not advance free pointer");
    a_word_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && item_reg.last |=> cursor_reg == '0 && !walk_stopped_reg
            && !overflow_reg && m_valid_reg)
        else $error("word end did not return walk to root");
`endif

endmodule

[hw/rtl/suffix_trie_best_match.sv]
// Top level: suffix trie best-match block, controller and datapath
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    stbm_in_t  (mode, letter, last, length, index)
//  m_       out        m_valid / m_ready    stbm_out_t (found, match_index, status)
//
//  Each transaction steps through child-table read, node-record read and commit.
//  The node-record read is addressed by the child-table read's result, so they run in turn.
//  A last-letter transaction holds in commit while the result register is full and m_ready is low.
//  Reset is synchronous and needs no clearing pass: a child link counts only if
//  the node it names is allocated and records this parent and letter.
module suffix_trie_best_match
    import stbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  stbm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output stbm_out_t m_data
);

    stbm_cmd_t  cmd;
    stbm_stat_t stat;

    stbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    stbm_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[tb/suffix_trie_best_match_test.sv]
// Testbench for the suffix trie best-match block: directed and random letter streams checked by a trie scoreboard
`timescale 1ns / 100ps

import stbm_pkg::*;

class trie_scoreboard;
    logic [NODE_W-1:0]     child_link [CHILD_DEPTH];
    logic [LEN_W-1:0]      node_len [NODE_COUNT];
    logic [IDX_W-1:0]      node_idx [NODE_COUNT];
    logic [ROOT_LEN_W-1:0] root_len;
    logic [IDX_W-1:0]      root_idx;
    logic                  root_has_word;
    logic [NODE_W:0]       free_node;
    logic [NODE_W-1:0]     cursor;
    bit                    stopped;
    bit                    overflowed;
    stbm_out_t             pending_results [$];
    int                    errors;

    function new();
        foreach (child_link[i]) child_link[i] = '0;
        foreach (node_len[i]) begin
            node_len[i] = '0;
            node_idx[i] = '0;
        end
        root_len      = ROOT_EMPTY_LEN;
        root_idx      = '0;
        root_has_word = 1'b0;
        free_node     = (NODE_W + 1)'(1);
        cursor        = '0;
        stopped       = 1'b0;
        overflowed    = 1'b0;
        errors        = 0;
    endfunction

    function bit store_full();
        return free_node == (NODE_W + 1)'(NODE_COUNT);
    endfunction

    // advance the trie walk by one accepted transaction
    function void note_letter(stbm_in_t it);
        logic [CHILD_AW-1:0] slot;
        logic [NODE_W-1:0]   kid;
        stbm_out_t           res;
        if (it.mode == MODE_INSERT) begin
            if ({1'b0, it.word_length} < root_len) begin
                root_len = {1'b0, it.word_length};
                root_idx = it.word_index;
            end
            root_has_word = 1'b1;
            if (!stopped) begin
                if (int'(it.letter) >= ALPHABET) begin
                    stopped = 1'b1;
                end else begin
                    slot = CHILD_AW'(cursor) * CHILD_AW'(ALPHABET) + CHILD_AW'(it.letter);
                    kid  = child_link[slot];
                    if (kid == '0) begin
                        if (store_full()) begin
                            overflowed = 1'b1;
                            stopped    = 1'b1;
                        end else begin
                            kid              = free_node[NODE_W-1:0];
                            free_node        = free_node + (NODE_W + 1)'(1);
                            child_link[slot] = kid;
                            node_len[kid]    = it.word_length;
                            node_idx[kid]    = it.word_index;
                            cursor           = kid;
                        end
                    end else begin
                        if (it.word_length < node_len[kid]) begin
                            node_len[kid] = it.word_length;
                            node_idx[kid] = it.word_index;
                        end
                        cursor = kid;
                    end
                end
            end
        end else if (!stopped) begin
            if (int'(it.letter) >= ALPHABET) begin
                stopped = 1'b1;
            end else begin
                slot = CHILD_AW'(cursor) * CHILD_AW'(ALPHABET) + CHILD_AW'(it.letter);
                kid  = child_link[slot];
                if (kid == '0) stopped = 1'b1;
                else cursor = kid;
            end
        end
        if (it.last) begin
            if (it.mode == MODE_INSERT) begin
                res.found       = 1'b1;
                res.match_index = '0;
                res.status      = overflowed;
            end else begin
                res.found       = root_has_word;
                res.match_index = (cursor == '0) ? root_idx : node_idx[cursor];
                res.status      = 1'b0;
            end
            pending_results.insert(pending_results.size(), res);
            cursor     = '0;
            stopped    = 1'b0;
            overflowed = 1'b0;
        end
    endfunction

    function void check_result(stbm_out_t got);
        stbm_out_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with none pending: found=%0d match_index=%h status=%0d",
                     $time, got.found, got.match_index, got.status);
            errors++;
        end else begin
            want = pending_results.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.match_index !== want.match_index) begin
                $display("%0t: match_index expected %h, got %h",
                         $time, want.match_index, got.match_index);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                errors++;
            end
        end
    endfunction
endclass

module suffix_trie_best_match_test;

    localparam int MAX_WORD     = 40;
    localparam int BANK         = 64;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 1000000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    stbm_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    stbm_out_t m_data;

    trie_scoreboard sb;

    logic [SYM_W-1:0] word_buf [MAX_WORD];
    logic [SYM_W-1:0] bank [BANK][MAX_WORD];
    int               bank_len [BANK];
    int               bank_total = 0;

    int items_sent  = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int cycles      = 0;
    int hold_request = 0;
    int hold_left   = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    suffix_trie_best_match uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= rx_left[0];
            endcase
        end
    end

    task automatic send_letter(input logic mode, input logic [SYM_W-1:0] letter,
                               input logic last, input logic [LEN_W-1:0] wlen,
                               input logic [IDX_W-1:0] widx);
        stbm_in_t it;
        int       gap;
        it.mode        = mode;
        it.letter      = letter;
        it.last        = last;
        it.word_length = wlen;
        it.word_index  = widx;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, gap_max);
            if (gap_max > 0 && $urandom_range(0, 7) == 0) gap = $urandom_range(10, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_letter(it);
        items_sent++;
    endtask

    task automatic send_word(input logic mode, input int n, input logic [LEN_W-1:0] wlen,
                             input logic [IDX_W-1:0] widx);
        for (int i = 0; i < n; i++) send_letter(mode, word_buf[i], i == n - 1, wlen, widx);
    endtask

    // hold the sender until every expected result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
        burst_left = 0;
    endtask

    function automatic void make_word(input int n, input bit narrow);
        for (int i = 0; i < n; i++) begin
            word_buf[i] = narrow ? SYM_W'($urandom_range(0, 3))
                                 : SYM_W'($urandom_range(0, ALPHABET - 1));
            if ($urandom_range(0, 24) == 0) word_buf[i] = SYM_W'($urandom_range(ALPHABET, 31));
        end
    endfunction

    function automatic void keep_word(input int n);
        int slot;
        slot = bank_total % BANK;
        for (int i = 0; i < n; i++) bank[slot][i] = word_buf[i];
        bank_len[slot] = n;
        bank_total++;
    endfunction

    function automatic int recall_word(input int slot);
        for (int i = 0; i < bank_len[slot]; i++) word_buf[i] = bank[slot][i];
        return bank_len[slot];
    endfunction

    function automatic logic [LEN_W-1:0] pick_length(input int n);
        case ($urandom_range(0, 3))
            0: return LEN_W'(n);
            1: return LEN_W'($urandom_range(1, 6));
            2: return LEN_W'($urandom_range(0, 4095));
            default: return 12'hFFF;
        endcase
    endfunction

    task automatic random_round();
        int pick;
        int n;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_WORD) : $urandom_range(1, 8);
            make_word(n, 1'($urandom_range(0, 1)));
            keep_word(n);
            send_word(MODE_INSERT, n, pick_length(n), IDX_W'($urandom_range(0, 65535)));
        end else if (pick < 75 && bank_total > 0) begin
            n = recall_word($urandom_range(0, (bank_total < BANK ? bank_total : BANK) - 1));
            k = $urandom_range(1, n);
            while (k < MAX_WORD && $urandom_range(0, 2) == 0) begin
                word_buf[k] = SYM_W'($urandom_range(0, ALPHABET - 1));
                k++;
            end
            send_word(MODE_QUERY, k, LEN_W'($urandom_range(0, 4095)),
                      IDX_W'($urandom_range(0, 65535)));
        end else if (pick < 85) begin
            n = $urandom_range(1, 6);
            make_word(n, 0);
            send_word(MODE_QUERY, n, LEN_W'($urandom_range(0, 4095)),
                      IDX_W'($urandom_range(0, 65535)));
        end else if (pick < 95) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_letter(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 31)), i == n - 1,
                            LEN_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 65535)));
        end else begin
            send_letter(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 31)),
                        1'($urandom_range(0, 1)),
                        LEN_W'($urandom_range(0, 4095)), IDX_W'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_letter(MODE_QUERY, 0, 1, 0, 0);
        send_letter(MODE_QUERY, 31, 1, 12'hFFF, 16'hFFFF);
        send_letter(MODE_INSERT, 2, 0, 3, 16'hFFFF);
        send_letter(MODE_INSERT, 0, 0, 3, 16'hFFFF);
        send_letter(MODE_INSERT, 19, 1, 3, 16'hFFFF);
        send_letter(MODE_INSERT, 2, 0, 12'hFFF, 16'h1234);
        send_letter(MODE_INSERT, 0, 1, 12'hFFF, 16'h1234);
        send_letter(MODE_INSERT, 2, 1, 1, 0);
        send_letter(MODE_INSERT, 2, 0, 3, 7);
        send_letter(MODE_INSERT, 0, 0, 3, 7);
        send_letter(MODE_INSERT, 19, 1, 3, 7);
        send_letter(MODE_INSERT, 25, 0, 0, 5);
        send_letter(MODE_INSERT, 30, 1, 0, 5);
        send_letter(MODE_QUERY, 2, 0, 0, 0);
        send_letter(MODE_QUERY, 0, 0, 0, 0);
        send_letter(MODE_QUERY, 19, 1, 0, 0);
        send_letter(MODE_QUERY, 2, 0, 0, 0);
        send_letter(MODE_QUERY, 0, 0, 0, 0);
        send_letter(MODE_QUERY, 4, 1, 0, 0);
        send_letter(MODE_QUERY, 7, 1, 0, 0);
        send_letter(MODE_INSERT, 2, 0, 9, 16'h00AA);
        send_letter(MODE_QUERY, 0, 1, 0, 0);
        send_letter(MODE_QUERY, 26, 1, 0, 0);
        drain_results();

        gap_max      = 6;
        hold_request = 600;
        while (items_sent < RANDOM_ITEMS / 2) random_round();
        drain_results();
        while (items_sent < RANDOM_ITEMS - 300) random_round();

        gap_max = 8;
        while (items_sent < RANDOM_ITEMS) random_round();

        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
